>>> rtl/bps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bps_pkg: shared types and constants of the beep pattern sequencer
// Command and pattern codes, register indexes, reset durations, and the
// structs that carry the sequencer state and the duration settings.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int unsigned DurW = 16;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [DurW-1:0] dur_t;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_PLAY = 2'd1,
    FUNC_STOP = 2'd2,
    FUNC_TEST = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    PAT_NONE     = 2'd0,
    PAT_SINGLE   = 2'd1,
    PAT_DOUBLE   = 2'd2,
    PAT_PERIODIC = 2'd3
  } pattern_t;

  // Phase steps within a pattern
  localparam logic [1:0] STEP_START  = 2'd0;
  localparam logic [1:0] STEP_FIRST  = 2'd1;
  localparam logic [1:0] STEP_SECOND = 2'd2;
  localparam logic [1:0] STEP_THIRD  = 2'd3;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_SINGLE_ON   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DOUBLE_ON   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DOUBLE_OFF  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PERIODIC_ON = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PERIODIC_OFF = 3'd4;

  // Reset durations in ticks
  localparam dur_t SINGLE_ON_RST    = 16'd100;
  localparam dur_t DOUBLE_ON_RST    = 16'd100;
  localparam dur_t DOUBLE_OFF_RST   = 16'd100;
  localparam dur_t PERIODIC_ON_RST  = 16'd100;
  localparam dur_t PERIODIC_OFF_RST = 16'd900;

  typedef struct packed {
    dur_t single_on;
    dur_t double_on;
    dur_t double_off;
    dur_t periodic_on;
    dur_t periodic_off;
  } cfg_t;

  typedef struct packed {
    pattern_t   pattern;
    logic [1:0] step;
    dur_t       ticks;
    logic       tone;
  } seq_state_t;

endpackage

`default_nettype wire

>>> rtl/beep_pattern_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// beep_pattern_sequencer: buzzer pattern sequencer
// Takes tick and command items, steps the single, double or periodic beep
// pattern, and returns the buzzer state and active pattern for every item.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_ready  | func[1:0], pattern_request[1:0]
//  out     | out_valid / out_ready| buzzer_on, active_pattern[1:0]
//  cfg     | cfg_we               | cfg_index[2:0], cfg_data[15:0]
//
// Each item is applied to the state in the cycle it is accepted; its result is
// registered in the output register, or in the skid entry while a result waits.
// One item per cycle while in_ready is high. A two-entry output buffer
// (output register plus skid entry) keeps input accepted while one result
// waits; in_ready drops only when both are full. Synchronous reset restores
// default durations, clears the pattern and silences the buzzer.
// ----------------------------------------------------------------------------
module beep_pattern_sequencer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   func,
  input  logic [1:0]                   pattern_request,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         buzzer_on,
  output logic [1:0]                   active_pattern,
  input  logic                         cfg_we,
  input  logic [bps_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [bps_pkg::DurW-1:0]     cfg_data
);
  import bps_pkg::*;

  cfg_t       cfg;
  seq_state_t state;
  seq_state_t state_next;

  logic       push;
  logic       pop;
  logic       skid_valid;
  logic       skid_buzzer_on;
  logic [1:0] skid_pattern;

  assign in_ready = !skid_valid;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  // Write duration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.single_on    <= SINGLE_ON_RST;
      cfg.double_on    <= DOUBLE_ON_RST;
      cfg.double_off   <= DOUBLE_OFF_RST;
      cfg.periodic_on  <= PERIODIC_ON_RST;
      cfg.periodic_off <= PERIODIC_OFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SINGLE_ON:    cfg.single_on    <= cfg_data;
        CFG_DOUBLE_ON:    cfg.double_on    <= cfg_data;
        CFG_DOUBLE_OFF:   cfg.double_off   <= cfg_data;
        CFG_PERIODIC_ON:  cfg.periodic_on  <= cfg_data;
        CFG_PERIODIC_OFF: cfg.periodic_off <= cfg_data;
        default: ;
      endcase
    end
  end

  bps_step u_step (
    .cur             (state),
    .cfg             (cfg),
    .func            (func),
    .pattern_request (pattern_request),
    .nxt             (state_next)
  );

  // Advance the sequencer state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      state.pattern <= PAT_NONE;
      state.step    <= STEP_START;
      state.ticks   <= '0;
      state.tone    <= 1'b0;
    end else if (push) begin
      state <= state_next;
    end
  end

  // Output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        buzzer_on      <= skid_buzzer_on;
        active_pattern <= skid_pattern;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_buzzer_on <= state_next.tone;
        skid_pattern   <= state_next.pattern;
      end else begin
        buzzer_on      <= state_next.tone;
        active_pattern <= state_next.pattern;
      end
    end
  end

  // The skid entry only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid without output register valid");

  // With no pattern the step is always back at the start
  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    (state.pattern == PAT_NONE) |-> (state.step == STEP_START))
    else $error("idle pattern with nonzero step");

  // A stop silences the buzzer and clears the pattern
  a_stop_silences: assert property (@(posedge clk) disable iff (rst)
    (push && (func == FUNC_STOP)) |=> (!state.tone && (state.pattern == PAT_NONE)))
    else $error("stop did not silence the buzzer");

  // A test item forces the tone on
  a_test_on: assert property (@(posedge clk) disable iff (rst)
    (push && (func == FUNC_TEST)) |=> state.tone)
    else $error("test did not force the tone on");

  // An accepted item always leaves a result waiting next cycle
  a_push_result: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid)
    else $error("accepted item produced no result");

endmodule

`default_nettype wire

>>> rtl/bps_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bps_step: next-state logic of the beep pattern sequencer
// Applies one command (tick, play, stop, test) to the sequencer state and
// returns the updated state. Purely combinational.
// ----------------------------------------------------------------------------
module bps_step (
  input  bps_pkg::seq_state_t cur,
  input  bps_pkg::cfg_t       cfg,
  input  logic [1:0]          func,
  input  logic [1:0]          pattern_request,
  output bps_pkg::seq_state_t nxt
);
  import bps_pkg::*;

  logic  expire;
  dur_t  ticks_dec;
  dur_t  start_dur;
  func_t cmd;

  assign cmd = func_t'(func);

  // Count down the running phase; expire when one or zero ticks remain
  assign expire    = (cur.ticks <= dur_t'(1));
  assign ticks_dec = expire ? '0 : cur.ticks - dur_t'(1);

  // Pick the on time that step zero loads
  always_comb begin
    case (cur.pattern)
      PAT_SINGLE: start_dur = cfg.single_on;
      PAT_DOUBLE: start_dur = cfg.double_on;
      default:    start_dur = cfg.periodic_on;
    endcase
  end

  always_comb begin
    nxt = cur;
    case (cmd)
      FUNC_TICK: begin
        if (cur.pattern == PAT_NONE) begin
          nxt = cur;
        end else if (cur.step == STEP_START) begin
          nxt.tone  = 1'b1;
          nxt.ticks = start_dur;
          nxt.step  = STEP_FIRST;
        end else begin
          case (cur.pattern)
            PAT_SINGLE: begin
              if (cur.step == STEP_FIRST) begin
                nxt.ticks = ticks_dec;
                if (expire) begin
                  nxt.tone    = 1'b0;
                  nxt.pattern = PAT_NONE;
                  nxt.step    = STEP_START;
                end
              end
            end
            PAT_DOUBLE: begin
              nxt.ticks = ticks_dec;
              if (expire) begin
                if (cur.step == STEP_FIRST) begin
                  nxt.tone  = 1'b0;
                  nxt.ticks = cfg.double_off;
                  nxt.step  = STEP_SECOND;
                end else if (cur.step == STEP_SECOND) begin
                  nxt.tone  = 1'b1;
                  nxt.ticks = cfg.double_on;
                  nxt.step  = STEP_THIRD;
                end else begin
                  nxt.tone    = 1'b0;
                  nxt.pattern = PAT_NONE;
                  nxt.step    = STEP_START;
                end
              end
            end
            default: begin
              // Periodic: step three has no meaning and is left alone
              if (cur.step != STEP_THIRD) begin
                nxt.ticks = ticks_dec;
                if (expire) begin
                  if (cur.step == STEP_FIRST) begin
                    nxt.tone  = 1'b0;
                    nxt.ticks = cfg.periodic_off;
                    nxt.step  = STEP_SECOND;
                  end else begin
                    nxt.step = STEP_START;
                  end
                end
              end
            end
          endcase
        end
      end
      FUNC_PLAY: begin
        // Replaying the active pattern is ignored
        if (pattern_t'(pattern_request) != cur.pattern) begin
          nxt.tone    = 1'b0;
          nxt.pattern = pattern_t'(pattern_request);
          nxt.step    = STEP_START;
        end
      end
      FUNC_STOP: begin
        nxt.tone    = 1'b0;
        nxt.pattern = PAT_NONE;
        nxt.step    = STEP_START;
      end
      default: begin
        nxt.tone = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire
